// ===== hw/rtl/aenc_pkg.sv =====
// Shared types and constants for the arithmetic encoder with E1/E2/E3 rescaling.
// Holds the request and result payload structs and the controller/datapath links.
// No dependencies.
package aenc_pkg;

    localparam int FOLLOW_W = 16;
    localparam int TAIL_W   = 23;
    localparam int TLEN_W   = 5;
    localparam logic [FOLLOW_W-1:0] PEND_MAX = 16'hFFFF;
    localparam int MAX_RESULTS = 32;
    localparam int NRES_W      = 6;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  symbol;
        logic [15:0] count_value;
        logic [15:0] total;
    } req_t;

    typedef struct packed {
        logic                lead_bit;
        logic [FOLLOW_W-1:0] follow_count;
        logic [TAIL_W-1:0]   tail_bits;
        logic [TLEN_W-1:0]   tail_len;
        logic                flush_byte;
        logic                error;
        logic                last;
    } res_t;

    typedef struct packed {
        logic load;
        logic write;
        logic sum_step;
        logic mul_hi;
        logic mul_lo;
        logic div_step;
        logic update;
        logic shift;
        logic final_push;
        logic emit_rej;
        logic emit_fin;
    } cmd_t;

    typedef struct packed {
        logic in_sym_ok;
        logic in_tot_ok;
        logic sum_at_sym;
        logic chk_fail;
        logic div_last;
        logic empty;
        logic shift_go;
        logic shift_wait;
        logic final_has;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/aenc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module aenc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/aenc_ctrl.sv =====
// Sequencing state machine of the arithmetic encoder.
// Depends on aenc_pkg for the command and status structs and request codes.
module aenc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [1:0]        req_type,
    input  aenc_pkg::sts_t    sts,
    output aenc_pkg::cmd_t    cmd,
    output logic              idle
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_SUM      = 12'b0000_0000_0010,
        ST_SUM_TAIL = 12'b0000_0000_0100,
        ST_CHECK    = 12'b0000_0000_1000,
        ST_MUL_HI   = 12'b0000_0001_0000,
        ST_MUL_LO   = 12'b0000_0010_0000,
        ST_DIV      = 12'b0000_0100_0000,
        ST_UPDATE   = 12'b0000_1000_0000,
        ST_SHIFT    = 12'b0001_0000_0000,
        ST_FINAL    = 12'b0010_0000_0000,
        ST_EMIT_REJ = 12'b0100_0000_0000,
        ST_EMIT_FIN = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd.load = 1'b1;
                    case (req_type)
                        aenc_pkg::REQ_WRITE:
                        begin
                            cmd.write = 1'b1;
                        end
                        aenc_pkg::REQ_ENCODE:
                        begin
                            if (sts.in_sym_ok && sts.in_tot_ok)
                            begin
                                state_next = ST_SUM;
                            end
                            else
                            begin
                                state_next = ST_EMIT_REJ;
                            end
                        end
                        aenc_pkg::REQ_FINISH:
                        begin
                            state_next = ST_EMIT_FIN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_at_sym)
                begin
                    state_next = ST_SUM_TAIL;
                end
            end
            ST_SUM_TAIL:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = sts.chk_fail ? ST_EMIT_REJ : ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (sts.empty)
                begin
                    state_next = ST_EMIT_REJ;
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (!sts.shift_go)
                begin
                    state_next = ST_FINAL;
                end
                else if (!sts.shift_wait)
                begin
                    cmd.shift = 1'b1;
                end
            end
            ST_FINAL:
            begin
                if (!sts.final_has)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.final_push = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT_REJ:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_rej = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_fin = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

// ===== hw/rtl/aenc_dp.sv =====
// Datapath of the arithmetic encoder: count table, prefix sum, multiply, divide,
// interval update, rescale shifter and result register.
// Depends on aenc_pkg and aenc_ram.
module aenc_dp #(
    parameter int CODE_BITS     = 24,
    parameter int ALPHABET_SIZE = 64,
    parameter int COUNT_BITS    = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  aenc_pkg::req_t   req,
    input  aenc_pkg::cmd_t   cmd,
    output aenc_pkg::sts_t   sts,
    output logic             res_valid,
    input  logic             res_stall,
    output aenc_pkg::res_t   res
);

    localparam int AW    = $clog2(ALPHABET_SIZE);
    localparam int SW    = ((AW > 6) ? AW : 6) + 1;
    localparam int CLW   = COUNT_BITS + AW;
    localparam int CHW   = CLW + 1;
    localparam int XW    = (CHW > 16) ? CHW : 16;
    localparam int RW    = CODE_BITS + 1;
    localparam int PW    = RW + 16;
    localparam int DCW   = $clog2(PW);
    localparam int GUARD = 2 * CODE_BITS + 2;
    localparam int GW    = $clog2(GUARD + 1);
    localparam int TW    = (CODE_BITS - 1 > aenc_pkg::TAIL_W) ? CODE_BITS - 1 : aenc_pkg::TAIL_W;

    // ---------------- request register and input checks ----------------
    aenc_pkg::req_t req_reg;
    logic [SW-1:0]  in_sym_x;
    logic [SW-1:0]  cur_sym_x;
    logic [AW-1:0]  sym_addr;

    assign in_sym_x      = SW'(req.symbol);
    assign cur_sym_x     = SW'(req_reg.symbol);
    assign sym_addr      = cur_sym_x[AW-1:0];
    assign sts.in_sym_ok = in_sym_x < SW'(ALPHABET_SIZE);
    assign sts.in_tot_ok = (req.total != 16'd0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    // ---------------- count table ----------------
    logic [ALPHABET_SIZE-1:0] valid_reg;
    logic [AW-1:0]            idx_reg;
    logic [COUNT_BITS-1:0]    rdata;
    logic                     rd_vld_reg;
    logic                     rd_pend_reg;
    logic                     rd_sym_reg;
    logic [COUNT_BITS-1:0]    entry;
    logic [SW-1:0]            wr_x;
    logic                     wr_en;

    assign wr_x  = in_sym_x;
    assign wr_en = cmd.write && sts.in_sym_ok;

    aenc_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(ALPHABET_SIZE)
    ) u_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_x[AW-1:0]),
        .wdata(COUNT_BITS'(req.count_value)),
        .raddr(idx_reg),
        .rdata(rdata)
    );

    assign entry          = rd_vld_reg ? rdata : '0;
    assign sts.sum_at_sym = (idx_reg == sym_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_pend_reg <= 1'b0;
            rd_sym_reg  <= 1'b0;
            rd_vld_reg  <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_x[AW-1:0]] <= 1'b1;
            end
            rd_pend_reg <= cmd.sum_step;
            rd_sym_reg  <= sts.sum_at_sym;
            rd_vld_reg  <= valid_reg[idx_reg];
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.sum_step)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    // ---------------- prefix sum ----------------
    logic [CLW-1:0]        cum_lo_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [CHW-1:0]        cum_hi;
    logic [XW-1:0]         cum_hi_x;
    logic [XW-1:0]         cum_lo_x;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cum_lo_reg <= '0;
            cnt_reg    <= '0;
        end
        else if (rd_pend_reg)
        begin
            if (rd_sym_reg)
            begin
                cnt_reg <= entry;
            end
            else
            begin
                cum_lo_reg <= cum_lo_reg + CLW'(entry);
            end
        end
    end

    assign cum_hi       = CHW'(cum_lo_reg) + CHW'(cnt_reg);
    assign cum_hi_x     = XW'(cum_hi);
    assign cum_lo_x     = XW'(cum_lo_reg);
    assign sts.chk_fail = (cnt_reg == '0) || (cum_hi_x > XW'(req_reg.total));

    // ---------------- interval registers ----------------
    logic [CODE_BITS-1:0] low_reg;
    logic [CODE_BITS-1:0] high_reg;
    logic [RW-1:0]        range;

    assign range = RW'(high_reg) - RW'(low_reg) + RW'(1);

    // ---------------- multiply into the dividers ----------------
    logic [15:0]   mul_op;
    logic [PW-1:0] product;
    logic [PW-1:0] dvd_hi_reg;
    logic [PW-1:0] dvd_lo_reg;
    logic [15:0]   rem_hi_reg;
    logic [15:0]   rem_lo_reg;
    logic [DCW-1:0] div_cnt_reg;

    assign mul_op  = cmd.mul_hi ? cum_hi_x[15:0] : cum_lo_x[15:0];
    assign product = PW'(range) * PW'(mul_op);

    // One restoring step: shift in the next dividend bit and subtract when it fits.
    logic [16:0] rs_hi;
    logic [16:0] rs_lo;
    logic        ge_hi;
    logic        ge_lo;
    logic [16:0] sub_hi;
    logic [16:0] sub_lo;

    assign rs_hi  = {rem_hi_reg, dvd_hi_reg[PW-1]};
    assign rs_lo  = {rem_lo_reg, dvd_lo_reg[PW-1]};
    assign ge_hi  = rs_hi >= {1'b0, req_reg.total};
    assign ge_lo  = rs_lo >= {1'b0, req_reg.total};
    assign sub_hi = rs_hi - {1'b0, req_reg.total};
    assign sub_lo = rs_lo - {1'b0, req_reg.total};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_hi)
        begin
            dvd_hi_reg  <= product;
            rem_hi_reg  <= '0;
            rem_lo_reg  <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.mul_lo)
        begin
            dvd_lo_reg <= product;
        end
        else if (cmd.div_step)
        begin
            dvd_hi_reg  <= {dvd_hi_reg[PW-2:0], ge_hi};
            dvd_lo_reg  <= {dvd_lo_reg[PW-2:0], ge_lo};
            rem_hi_reg  <= ge_hi ? sub_hi[15:0] : rs_hi[15:0];
            rem_lo_reg  <= ge_lo ? sub_lo[15:0] : rs_lo[15:0];
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
    end

    assign sts.div_last = (div_cnt_reg == DCW'(PW - 1));
    assign sts.empty    = (dvd_hi_reg <= dvd_lo_reg);

    // ---------------- rescaling ----------------
    logic [RW-1:0]        upd_hi;
    logic [RW-1:0]        upd_lo;
    logic                 e12;
    logic                 e3;
    logic [GW-1:0]        guard_reg;
    logic                 guard_done;
    logic [aenc_pkg::FOLLOW_W-1:0] pend_reg;
    logic                 ovf_reg;
    logic [aenc_pkg::NRES_W-1:0] nres_reg;
    logic                 n_full;
    logic                 put;
    aenc_pkg::res_t       held_reg;
    logic                 held_valid_reg;
    aenc_pkg::res_t       new_res;
    aenc_pkg::res_t       err_res;
    logic [TW-1:0]        tail_x;

    assign upd_hi = RW'(low_reg) + dvd_hi_reg[RW-1:0] - RW'(1);
    assign upd_lo = RW'(low_reg) + dvd_lo_reg[RW-1:0];

    assign e12 = (low_reg[CODE_BITS-1] == high_reg[CODE_BITS-1]);
    assign e3  = !e12 && (low_reg[CODE_BITS-1:CODE_BITS-2] == 2'b01)
                      && (high_reg[CODE_BITS-1:CODE_BITS-2] == 2'b10);
    assign guard_done = (guard_reg == GW'(GUARD));
    assign n_full     = (nres_reg == aenc_pkg::NRES_W'(aenc_pkg::MAX_RESULTS));
    assign put        = e12 && !n_full;

    assign sts.shift_go   = (e12 || e3) && !guard_done;
    assign sts.shift_wait = put && held_valid_reg && !sts.out_free;
    assign sts.final_has  = held_valid_reg || ovf_reg;

    always_comb
    begin
        new_res              = '0;
        new_res.lead_bit     = low_reg[CODE_BITS-1];
        new_res.follow_count = pend_reg;
        err_res              = '0;
        err_res.error        = 1'b1;
        err_res.last         = 1'b1;
    end

    assign tail_x = TW'(low_reg[CODE_BITS-2:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg        <= '0;
            high_reg       <= '1;
            pend_reg       <= '0;
            held_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            nres_reg       <= '0;
            guard_reg      <= '0;
        end
        else if (cmd.update)
        begin
            low_reg        <= upd_lo[CODE_BITS-1:0];
            high_reg       <= upd_hi[CODE_BITS-1:0];
            held_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            nres_reg       <= '0;
            guard_reg      <= '0;
        end
        else if (cmd.shift)
        begin
            guard_reg <= guard_reg + GW'(1);
            if (e12)
            begin
                if (put)
                begin
                    held_valid_reg <= 1'b1;
                    nres_reg       <= nres_reg + aenc_pkg::NRES_W'(1);
                end
                pend_reg <= '0;
                low_reg  <= {low_reg[CODE_BITS-2:0], 1'b0};
                high_reg <= {high_reg[CODE_BITS-2:0], 1'b1};
            end
            else
            begin
                if (pend_reg == aenc_pkg::PEND_MAX)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= pend_reg + aenc_pkg::FOLLOW_W'(1);
                end
                low_reg  <= {1'b0, low_reg[CODE_BITS-3:0], 1'b0};
                high_reg <= {1'b1, high_reg[CODE_BITS-3:0], 1'b1};
            end
        end
        else if (cmd.final_push)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (cmd.emit_fin)
        begin
            pend_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift && put)
        begin
            held_reg <= new_res;
        end
    end

    // ---------------- result register ----------------
    logic           out_load;
    aenc_pkg::res_t out_next;
    aenc_pkg::res_t res_reg;
    logic           res_valid_reg;

    assign sts.out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        out_load = 1'b0;
        out_next = held_reg;
        if (cmd.shift && put && held_valid_reg)
        begin
            out_load      = 1'b1;
            out_next.last = 1'b0;
        end
        else if (cmd.final_push)
        begin
            out_load = 1'b1;
            if (held_valid_reg)
            begin
                out_next.error = held_reg.error | ovf_reg;
                out_next.last  = 1'b1;
            end
            else
            begin
                out_next = err_res;
            end
        end
        else if (cmd.emit_rej)
        begin
            out_load = 1'b1;
            out_next = err_res;
        end
        else if (cmd.emit_fin)
        begin
            out_load              = 1'b1;
            out_next              = '0;
            out_next.lead_bit     = low_reg[CODE_BITS-1];
            out_next.follow_count = pend_reg;
            out_next.tail_bits    = tail_x[aenc_pkg::TAIL_W-1:0];
            out_next.tail_len     = aenc_pkg::TLEN_W'(CODE_BITS - 1);
            out_next.flush_byte   = 1'b1;
            out_next.last         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg <= out_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/arith_encoder_e123_scaling.sv =====
// Arithmetic encoder top level. A count write is taken while idle and a finish emits its result;
// an encode runs the prefix sum up to the symbol, multiplies the range by the high and then the
// low cumulative count, takes CODE_BITS + 17 divider steps, updates the interval, rescales with
// at most 2 * CODE_BITS + 2 shifts, waiting on a full output, and pushes the final result.
// One item is in work at a time; a result waits in an output register and stalls add on.
// Reset clears the count table valid bits and the pending count and sets the full interval at once.
module arith_encoder_e123_scaling #(
    parameter int CODE_BITS     = 24,
    parameter int ALPHABET_SIZE = 64,
    parameter int COUNT_BITS    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  aenc_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_stall,
    output aenc_pkg::res_t res
);

    aenc_pkg::cmd_t cmd;
    aenc_pkg::sts_t sts;
    logic           idle;
    logic           take;

    assign req_stall = !idle;
    assign take      = req_valid && idle;

    aenc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .req_type(req.req_type),
        .sts     (sts),
        .cmd     (cmd),
        .idle    (idle)
    );

    aenc_dp #(
        .CODE_BITS    (CODE_BITS),
        .ALPHABET_SIZE(ALPHABET_SIZE),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .sts      (sts),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

endmodule

// ===== hw/rtl/aenc_chk.sv =====
// Port-level checker for the arithmetic encoder, bound to the top level.
// Depends on aenc_pkg and arith_encoder_e123_scaling.
module aenc_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input aenc_pkg::req_t req,
    input logic           res_valid,
    input logic           res_stall,
    input aenc_pkg::res_t res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result valid dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("stalled result changed");

    // A result that is not the last of its item means the encoder is still busy.
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last |-> req_stall)
        else $error("non-final result shown while encoder idle");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.flush_byte |-> res.last && !res.error && res.tail_len != 5'd0)
        else $error("finish result malformed");

endmodule

bind arith_encoder_e123_scaling aenc_chk u_chk (.*);
